// ===== hdl/mcg_pkg.sv =====
`timescale 1ns / 1ps

package mcg_pkg;

    localparam int MAX_ROW_SIZE = 64;
    localparam int MAX_LENGTH   = 16;
    localparam int ROW_BITS     = $clog2(MAX_ROW_SIZE);

    localparam int SYM_W        = 8;
    localparam int SEED_W       = 64;
    localparam int CMD_W        = 2;
    localparam int COL_W        = 6;
    localparam int ROWS         = 1 << SYM_W;
    localparam int TRANS_DEPTH  = ROWS * MAX_ROW_SIZE;

    localparam int CFG_BITS_W   = 3;
    localparam int CFG_LEN_W    = 5;
    localparam int CFG_DATA_W   = 5;
    localparam int CFG_IDX_W    = 1;

    localparam int RUN_FEEDBACK_SHIFT = 17;

    localparam logic [CFG_BITS_W-1:0] INDEX_BITS_RESET    = 3'd6;
    localparam logic [CFG_LEN_W-1:0]  OUTPUT_LENGTH_RESET = 5'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LENGTH = 1'd1;

    localparam logic [CMD_W-1:0] CMD_LOAD_FIRST = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_TRANS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GENERATE   = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIRST,
        S_NEXT
    } state_t;

endpackage

// ===== hdl/mcg_ram.sv =====
`timescale 1ns / 1ps

module mcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/markov_candidate_generator.sv =====
`timescale 1ns / 1ps

// Markov-chain candidate generator. A load transfer (cmd 0 or 1) writes one byte of the
// first-symbol table or of a transition row. A generate transfer (cmd 2) emits
// output_length bytes, clamped to 1..16, one output transfer each, with last on the final
// byte. The block holds one generate item at a time: it reads the first-symbol table
// and then emits one byte per cycle while the output side is ready, set by the
// transition-table read whose address depends on the previously read byte. A byte
// whose transition row was never loaded comes out as zero with missing_row set, and the
// chain continues from row zero. Tables hold no reset value; of their state only the
// per-row loaded flags are cleared by reset. Configuration writes take effect for the
// next generate transfer.
module markov_candidate_generator
    import mcg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CMD_W-1:0]      cmd,
    input  logic [SEED_W-1:0]     seed,
    input  logic [SYM_W-1:0]      row_byte,
    input  logic [COL_W-1:0]      column,
    input  logic [SYM_W-1:0]      entry_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SYM_W-1:0]      symbol,
    output logic                  last,
    output logic                  missing_row
);

    state_t state_reg, state_next;

    logic [CFG_BITS_W-1:0] cfg_bits_reg;
    logic [CFG_LEN_W-1:0]  cfg_len_reg;

    logic [SEED_W-1:0]     seed_reg, seed_next;
    logic [SEED_W-1:0]     run_reg, run_next;
    logic [CFG_BITS_W-1:0] bits_reg, bits_next;
    logic [ROW_BITS-1:0]   mask_reg, mask_next;
    logic [CFG_LEN_W-1:0]  len_reg, len_next;
    logic [CFG_LEN_W-1:0]  count_reg, count_next;
    logic                  loaded_reg, loaded_next;
    logic [ROWS-1:0]       row_loaded_reg;

    logic                  out_valid_reg;
    logic [SYM_W-1:0]      symbol_reg;
    logic                  last_reg;
    logic                  missing_reg;

    logic                  in_accept;
    logic                  emit;
    logic                  is_last;
    logic [CFG_BITS_W-1:0] bits_sat;
    logic [CFG_LEN_W-1:0]  len_sat;
    logic [ROW_BITS-1:0]   gen_mask;
    logic [SEED_W-1:0]     shifted;
    logic [SEED_W-1:0]     run_upd;
    logic [SYM_W-1:0]      cur_sym;
    logic                  cur_miss;
    logic [ROW_BITS-1:0]   next_pos;

    logic                          first_we, first_re;
    logic [ROW_BITS-1:0]           first_raddr;
    logic [SYM_W-1:0]              first_rdata;
    logic                          trans_we, trans_re;
    logic [SYM_W+ROW_BITS-1:0]     trans_waddr, trans_raddr;
    logic [SYM_W-1:0]              trans_rdata;
    logic                          col_ok;

    // Configuration registers, saturated where they are used.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_bits_reg <= INDEX_BITS_RESET;
            cfg_len_reg  <= OUTPUT_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INDEX_BITS:    cfg_bits_reg <= cfg_data[CFG_BITS_W-1:0];
                CFG_OUTPUT_LENGTH: cfg_len_reg  <= cfg_data[CFG_LEN_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        if (cfg_bits_reg == '0)
            bits_sat = CFG_BITS_W'(1);
        else if (cfg_bits_reg > CFG_BITS_W'(ROW_BITS))
            bits_sat = CFG_BITS_W'(ROW_BITS);
        else
            bits_sat = cfg_bits_reg;

        if (cfg_len_reg == '0)
            len_sat = CFG_LEN_W'(1);
        else if (cfg_len_reg > CFG_LEN_W'(MAX_LENGTH))
            len_sat = CFG_LEN_W'(MAX_LENGTH);
        else
            len_sat = cfg_len_reg;

        gen_mask = ~({ROW_BITS{1'b1}} << bits_sat);
    end

    assign in_accept = in_valid && in_ready;
    assign col_ok    = int'(column) < MAX_ROW_SIZE;

    // Running value update: the first step omits the feedback term.
    always_comb
    begin
        shifted = run_reg >> bits_reg;
        if (state_reg == S_FIRST)
            run_upd = shifted ^ seed_reg;
        else
            run_upd = shifted ^ seed_reg ^ (shifted << RUN_FEEDBACK_SHIFT);
        next_pos = run_upd[ROW_BITS-1:0] & mask_reg;
    end

    always_comb
    begin
        if (state_reg == S_FIRST)
        begin
            cur_sym  = first_rdata;
            cur_miss = 1'b0;
        end
        else
        begin
            cur_sym  = loaded_reg ? trans_rdata : '0;
            cur_miss = !loaded_reg;
        end
        is_last = (count_reg == len_reg - CFG_LEN_W'(1));
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && cmd == CMD_GENERATE)
                    state_next = S_FIRST;
            end
            S_FIRST, S_NEXT:
            begin
                if (emit)
                    state_next = is_last ? S_IDLE : S_NEXT;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control outputs of the state machine.
    always_comb
    begin
        in_ready = 1'b0;
        emit     = 1'b0;
        case (state_reg)
            S_IDLE:          in_ready = 1'b1;
            S_FIRST, S_NEXT: emit = !out_valid_reg || out_ready;
            default:         ;
        endcase
    end

    // Memory ports. First-table reads happen on generate accept, transition reads only when a
    // byte moves on, so the read data holds while the output side stalls.
    always_comb
    begin
        first_we    = in_accept && cmd == CMD_LOAD_FIRST && col_ok;
        first_re    = in_accept && cmd == CMD_GENERATE;
        first_raddr = seed[ROW_BITS-1:0] & gen_mask;
        trans_we    = in_accept && cmd == CMD_LOAD_TRANS && col_ok;
        trans_waddr = {row_byte, column[ROW_BITS-1:0]};
        trans_re    = emit && !is_last;
        trans_raddr = {cur_sym, next_pos};
    end

    mcg_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_ROW_SIZE)
    ) u_first_ram (
        .clk   (clk),
        .we    (first_we),
        .waddr (column[ROW_BITS-1:0]),
        .wdata (entry_value),
        .re    (first_re),
        .raddr (first_raddr),
        .rdata (first_rdata)
    );

    mcg_ram #(
        .WIDTH (SYM_W),
        .DEPTH (TRANS_DEPTH)
    ) u_trans_ram (
        .clk   (clk),
        .we    (trans_we),
        .waddr (trans_waddr),
        .wdata (entry_value),
        .re    (trans_re),
        .raddr (trans_raddr),
        .rdata (trans_rdata)
    );

    // Datapath next values.
    always_comb
    begin
        seed_next   = seed_reg;
        run_next    = run_reg;
        bits_next   = bits_reg;
        mask_next   = mask_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        loaded_next = loaded_reg;
        if (in_accept && cmd == CMD_GENERATE)
        begin
            seed_next  = seed;
            run_next   = seed;
            bits_next  = bits_sat;
            mask_next  = gen_mask;
            len_next   = len_sat;
            count_next = '0;
        end
        else if (emit)
        begin
            run_next    = run_upd;
            count_next  = count_reg + CFG_LEN_W'(1);
            loaded_next = row_loaded_reg[cur_sym];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            row_loaded_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (trans_we)
                row_loaded_reg[row_byte] <= 1'b1;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        seed_reg   <= seed_next;
        run_reg    <= run_next;
        bits_reg   <= bits_next;
        mask_reg   <= mask_next;
        len_reg    <= len_next;
        count_reg  <= count_next;
        loaded_reg <= loaded_next;
        if (emit)
        begin
            symbol_reg  <= cur_sym;
            last_reg    <= is_last;
            missing_reg <= cur_miss;
        end
    end

    assign out_valid   = out_valid_reg;
    assign symbol      = symbol_reg;
    assign last        = last_reg;
    assign missing_row = missing_reg;

endmodule

// ===== dv/tb_markov_candidate_generator.sv =====
`timescale 1ns / 1ps

module tb_markov_candidate_generator;
    import mcg_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int TARGET_ITEMS = 470;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             missing_row;
    } plain_byte_t;

    // One row of the directed table. A config row writes both registers once the
    // block is idle. A generate row with n_typed set carries its results inline.
    typedef struct packed {
        logic                  is_config;
        logic [CMD_W-1:0]      cmd;
        logic [SEED_W-1:0]     seed;
        logic [SYM_W-1:0]      row_byte;
        logic [COL_W-1:0]      column;
        logic [SYM_W-1:0]      value;
        logic [CFG_DATA_W-1:0] bits_data;
        logic [CFG_DATA_W-1:0] len_data;
        logic [1:0]            n_typed;
        plain_byte_t           typed0;
        plain_byte_t           typed1;
    } step_t;

    localparam int N_DIRECTED = 23;
    localparam plain_byte_t NONE = '0;

    step_t directed_steps [N_DIRECTED] = '{
        '{1'b1, CMD_UNUSED, '0, 8'h00, 6'h00, 8'h00, 5'd1, 5'd1, 2'd0, NONE, NONE},
        '{1'b0, CMD_LOAD_FIRST, '0, 8'h00, 6'h00, 8'h00, 5'd0, 5'd0, 2'd0, NONE, NONE},
        '{1'b0, CMD_LOAD_FIRST, '0, 8'h00, 6'h01, 8'hFF, 5'd0, 5'd0, 2'd0, NONE, NONE},
        '{1'b0, CMD_GENERATE, '0, 8'h00, 6'h00, 8'h00, 5'd0, 5'd0, 2'd1,
          {8'h00, 2'b10}, NONE},
        '{1'b0, CMD_GENERATE, '1, 8'h00, 6'h00, 8'h00, 5'd0, 5'd0, 2'd1,
          {8'hFF, 2'b10}, NONE},
        '{1'b0, CMD_UNUSED, '1, 8'hFF, 6'h3F, 8'hFF, 5'd0, 5'd0, 2'd0, NONE, NONE},
        '{1'b1, CMD_UNUSED, '0, 8'h00, 6'h00, 8'h00, 5'd1, 5'd2, 2'd0, NONE, NONE},
        '{1'b0, CMD_GENERATE, '0, 8'h00, 6'h00, 8'h00, 5'd0, 5'd0, 2'd2,
          {8'h00, 2'b00}, {8'h00, 2'b11}},
        '{1'b0, CMD_LOAD_TRANS, '0, 8'h00, 6'h00, 8'hFF, 5'd0, 5'd0, 2'd0, NONE, NONE},
        '{1'b0, CMD_GENERATE, '0, 8'h00, 6'h00, 8'h00, 5'd0, 5'd0, 2'd2,
          {8'h00, 2'b00}, {8'hFF, 2'b10}},
        '{1'b1, CMD_UNUSED, '0, 8'h00, 6'h00, 8'h00, 5'd7, 5'd31, 2'd0, NONE, NONE},
        '{1'b0, CMD_GENERATE, '0, 8'h00, 6'h00, 8'h00, 5'd0, 5'd0, 2'd0, NONE, NONE},
        '{1'b0, CMD_LOAD_TRANS, '0, 8'hFF, 6'h3F, 8'h5A, 5'd0, 5'd0, 2'd0, NONE, NONE},
        '{1'b0, CMD_LOAD_FIRST, '0, 8'h00, 6'h3F, 8'hA5, 5'd0, 5'd0, 2'd0, NONE, NONE},
        '{1'b0, CMD_GENERATE, '1, 8'h00, 6'h00, 8'h00, 5'd0, 5'd0, 2'd0, NONE, NONE},
        '{1'b1, CMD_UNUSED, '0, 8'h00, 6'h00, 8'h00, 5'd0, 5'd0, 2'd0, NONE, NONE},
        '{1'b0, CMD_GENERATE, 64'd1, 8'h00, 6'h00, 8'h00, 5'd0, 5'd0, 2'd1,
          {8'hFF, 2'b10}, NONE},
        '{1'b1, CMD_UNUSED, '0, 8'h00, 6'h00, 8'h00, 5'h1F, 5'd16, 2'd0, NONE, NONE},
        '{1'b0, CMD_GENERATE, 64'hDEAD_BEEF_0123_4567, 8'h00, 6'h00, 8'h00,
          5'd0, 5'd0, 2'd0, NONE, NONE},
        '{1'b0, CMD_UNUSED, '0, 8'h00, 6'h00, 8'h00, 5'd0, 5'd0, 2'd0, NONE, NONE},
        '{1'b1, CMD_UNUSED, '0, 8'h00, 6'h00, 8'h00, 5'd3, 5'd5, 2'd0, NONE, NONE},
        '{1'b0, CMD_GENERATE, 64'h8000_0000_0000_0000, 8'h00, 6'h00, 8'h00,
          5'd0, 5'd0, 2'd0, NONE, NONE},
        '{1'b0, CMD_LOAD_TRANS, '0, 8'h81, 6'h15, 8'h3C, 5'd0, 5'd0, 2'd0, NONE, NONE}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [CMD_W-1:0]      cmd = '0;
    logic [SEED_W-1:0]     seed = '0;
    logic [SYM_W-1:0]      row_byte = '0;
    logic [COL_W-1:0]      column = '0;
    logic [SYM_W-1:0]      entry_value = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b1;
    logic [SYM_W-1:0]      symbol;
    logic                  last;
    logic                  missing_row;

    // Mirror of the block's tables and registers.
    logic [SYM_W-1:0]      first_tab [MAX_ROW_SIZE];
    bit                    first_written [MAX_ROW_SIZE];
    logic [SYM_W-1:0]      trans_tab [TRANS_DEPTH];
    bit                    trans_written [TRANS_DEPTH];
    bit                    row_loaded [ROWS];
    logic [CFG_BITS_W-1:0] cur_index_bits = INDEX_BITS_RESET;
    logic [CFG_LEN_W-1:0]  cur_length = OUTPUT_LENGTH_RESET;

    plain_byte_t           expected_bytes [$];
    logic [SYM_W-1:0]      sym_pool [8];
    bit                    no_idle = 1'b0;

    int items_sent = 0;
    int generates = 0;
    int bytes_checked = 0;
    int missing_seen = 0;
    int settings_used = 0;
    int failures = 0;

    markov_candidate_generator i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .seed        (seed),
        .row_byte    (row_byte),
        .column      (column),
        .entry_value (entry_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .symbol      (symbol),
        .last        (last),
        .missing_row (missing_row)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SYM_W-1:0] pick_symbol();
        if ($urandom_range(0, 99) < 85)
            return sym_pool[$urandom_range(0, 7)];
        return SYM_W'($urandom_range(0, 255));
    endfunction

    // Walks the chain for one seed. Returns 1 and the position of the first table
    // entry that would be read before it was ever written; otherwise returns 0 and,
    // with commit set, queues the bytes the block must produce.
    function automatic bit predict_plaintext(input logic [SEED_W-1:0] s, input bit commit,
                                             output bit hole_first,
                                             output logic [SYM_W-1:0] hole_row,
                                             output logic [COL_W-1:0] hole_col);
        int unsigned       nbits;
        int unsigned       nbytes;
        logic [SEED_W-1:0] mask;
        logic [SEED_W-1:0] run;
        logic [COL_W-1:0]  pos;
        logic [SYM_W-1:0]  prev;
        logic [SYM_W-1:0]  sym;
        bit                miss;
        nbits = (cur_index_bits < 1) ? 1 : cur_index_bits;
        if (nbits > ROW_BITS)
            nbits = ROW_BITS;
        nbytes = (cur_length < 1) ? 1 : cur_length;
        if (nbytes > MAX_LENGTH)
            nbytes = MAX_LENGTH;
        hole_first = 1'b0;
        hole_row = '0;
        hole_col = '0;
        mask = (64'd1 << nbits) - 64'd1;
        run = s;
        pos = COL_W'(run & mask);
        if (!first_written[pos])
        begin
            hole_first = 1'b1;
            hole_col = pos;
            return 1'b1;
        end
        prev = first_tab[pos];
        if (commit)
            expected_bytes.push_back('{prev, nbytes == 1, 1'b0});
        run = (run >> nbits) ^ s;
        for (int i = 1; i < nbytes; i++)
        begin
            pos = COL_W'(run & mask);
            sym = '0;
            miss = 1'b1;
            // An unloaded row yields zero, so the chain carries on from row zero.
            if (row_loaded[prev])
            begin
                if (!trans_written[{prev, pos}])
                begin
                    hole_row = prev;
                    hole_col = pos;
                    return 1'b1;
                end
                sym = trans_tab[{prev, pos}];
                miss = 1'b0;
            end
            if (commit)
                expected_bytes.push_back('{sym, i + 1 == nbytes, miss});
            prev = sym;
            run = run >> nbits;
            run = run ^ s ^ (run << RUN_FEEDBACK_SHIFT);
        end
        return 1'b0;
    endfunction

    // Must be entered right after a rising edge; returns at the edge of the transfer.
    task automatic drive_item(input logic [CMD_W-1:0] c, input logic [SEED_W-1:0] s,
                              input logic [SYM_W-1:0] r, input logic [COL_W-1:0] col,
                              input logic [SYM_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        seed        <= s;
        row_byte    <= r;
        column      <= col;
        entry_value <= v;
        do
            @(posedge clk);
        while (!in_ready);
        if (c != CMD_UNUSED)
            items_sent++;
    endtask

    task automatic issue_load(input logic [CMD_W-1:0] c, input logic [SYM_W-1:0] r,
                              input logic [COL_W-1:0] col, input logic [SYM_W-1:0] v);
        if (c == CMD_LOAD_FIRST)
        begin
            first_tab[col] = v;
            first_written[col] = 1'b1;
        end
        else
        begin
            trans_tab[{r, col}] = v;
            trans_written[{r, col}] = 1'b1;
            row_loaded[r] = 1'b1;
        end
        drive_item(c, {$urandom, $urandom}, r, col, v);
    endtask

    // Any entry the chain would read before it is written gets loaded first.
    task automatic issue_generate(input logic [SEED_W-1:0] s);
        bit               hole_first;
        logic [SYM_W-1:0] hole_row;
        logic [COL_W-1:0] hole_col;
        while (predict_plaintext(s, 1'b0, hole_first, hole_row, hole_col))
        begin
            if (hole_first)
                issue_load(CMD_LOAD_FIRST, SYM_W'($urandom), hole_col, pick_symbol());
            else
                issue_load(CMD_LOAD_TRANS, hole_row, hole_col, pick_symbol());
        end
        void'(predict_plaintext(s, 1'b1, hole_first, hole_row, hole_col));
        generates++;
        drive_item(CMD_GENERATE, s, SYM_W'($urandom), COL_W'($urandom), SYM_W'($urandom));
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (MAX_LENGTH + 4) @(posedge clk);
    endtask

    task automatic write_config(input logic [CFG_DATA_W-1:0] bits_data,
                                input logic [CFG_DATA_W-1:0] len_data);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_INDEX_BITS;
        cfg_data  <= bits_data;
        cur_index_bits = bits_data[CFG_BITS_W-1:0];
        @(posedge clk);
        cfg_index <= CFG_OUTPUT_LENGTH;
        cfg_data  <= len_data;
        cur_length = len_data[CFG_LEN_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    initial
    begin
        int    r;
        step_t st;
        foreach (sym_pool[k])
            sym_pool[k] = SYM_W'($urandom_range(0, 255));
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < N_DIRECTED; k++)
        begin
            st = directed_steps[k];
            if (st.is_config)
            begin
                go_idle();
                write_config(st.bits_data, st.len_data);
            end
            else if (st.n_typed != 0)
            begin
                expected_bytes.push_back(st.typed0);
                if (st.n_typed == 2)
                    expected_bytes.push_back(st.typed1);
                generates++;
                drive_item(st.cmd, st.seed, st.row_byte, st.column, st.value);
            end
            else if (st.cmd == CMD_GENERATE)
                issue_generate(st.seed);
            else if (st.cmd == CMD_UNUSED)
                drive_item(st.cmd, st.seed, st.row_byte, st.column, st.value);
            else
                issue_load(st.cmd, st.row_byte, st.column, st.value);
        end

        // Random phases: a fresh setting, then loads that build up rows from a small
        // symbol pool so that chains stay in loaded rows, mixed with generates.
        while (items_sent < TARGET_ITEMS)
        begin
            go_idle();
            no_idle = ($urandom_range(0, 4) == 0);
            write_config(($urandom_range(0, 9) < 7) ? CFG_DATA_W'($urandom_range(1, 6))
                                                     : CFG_DATA_W'($urandom),
                         ($urandom_range(0, 9) < 6) ? CFG_DATA_W'($urandom_range(1, 8))
                                                     : CFG_DATA_W'($urandom));
            if ($urandom_range(0, 1) == 1)
                foreach (sym_pool[k])
                    sym_pool[k] = SYM_W'($urandom_range(0, 255));
            repeat ($urandom_range(20, 50))
            begin
                if (items_sent >= TARGET_ITEMS)
                    break;
                r = $urandom_range(0, 99);
                if (r < 5)
                    drive_item(CMD_UNUSED, {$urandom, $urandom}, SYM_W'($urandom),
                               COL_W'($urandom), SYM_W'($urandom));
                else if (r < 35)
                    issue_load(CMD_LOAD_TRANS, pick_symbol(), COL_W'($urandom),
                               pick_symbol());
                else if (r < 45)
                    issue_load(CMD_LOAD_FIRST, SYM_W'($urandom), COL_W'($urandom),
                               pick_symbol());
                else if (r < 92)
                    issue_generate({$urandom, $urandom});
                else
                    issue_generate((r < 96) ? '0 : '1);
            end
        end
        no_idle = 1'b0;
        go_idle();

        $display("Sent %0d input transfers (%0d generates) over %0d register settings.",
                 items_sent, generates, settings_used);
        $display("Checked %0d output bytes, %0d of them on a missing row; %0d failures.",
                 bytes_checked, missing_seen, failures);
        if (failures == 0 && expected_bytes.size() == 0)
            $display("** markov_candidate_generator: PASSED **");
        else
            $display("** markov_candidate_generator: FAILED **");
        $finish;
    end

    // Output backpressure: runs of ready broken by stalls of random length.
    initial
    begin
        int stall;
        forever
        begin
            repeat ($urandom_range(1, 12)) @(posedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_bytes
        plain_byte_t want;
        if (rst_n && out_valid && out_ready)
        begin
            bytes_checked++;
            if (missing_row)
                missing_seen++;
            if (expected_bytes.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: unexpected byte %h last %b missing_row %b",
                             $realtime, symbol, last, missing_row);
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (symbol !== want.symbol || last !== want.last
                    || missing_row !== want.missing_row)
                begin
                    failures++;
                    if (failures <= 10)
                    begin
                        $display("%0t: byte mismatch: expected %h last %b missing_row %b,",
                                 $realtime, want.symbol, want.last, want.missing_row);
                        $display("    got %h last %b missing_row %b",
                                 symbol, last, missing_row);
                    end
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("Timeout with %0d bytes still expected.", expected_bytes.size());
        $display("** markov_candidate_generator: FAILED **");
        $finish;
    end

endmodule
